>>> rtl/lzc_pkg.sv
// Shared constants and types of the greedy LZ77 byte compressor.
package lzc_pkg;

    localparam int LZC_WINDOW_DEF    = 255;
    localparam int LZC_MAX_MATCH_DEF = 15;
    localparam int LZC_MIN_MATCH_DEF = 3;

    // Width of a byte and of a match distance.
    localparam int LZC_BYTE_W = 8;
    localparam int LZC_DIST_W = 8;
    localparam int LZC_LEN_OUT_W = 4;

    // Group size of the two-level farthest-match search.
    localparam int LZC_GROUP   = 16;
    localparam int LZC_GROUP_W = 4;

    // Control broadcast to every cell of the history chain.
    typedef struct packed {
        logic push;    // shift one byte into the history
        logic clear;   // forget the whole history
        logic load;    // copy history to scan chain, arm cells with history
        logic commit;  // accept this scan step and shift the scan chain
    } t_cell_ctl;

endpackage

>>> rtl/lzc_cell.sv
// One history cell: a stored byte, a scan byte and a match flag for one distance.
module lzc_cell
    import lzc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [LZC_BYTE_W-1:0] i_hist_prev,
    input  logic                  i_hist_vld_prev,
    input  logic [LZC_BYTE_W-1:0] i_scan_prev,
    input  logic                  i_scan_vld_prev,
    input  logic [LZC_BYTE_W-1:0] i_look,
    output logic [LZC_BYTE_W-1:0] o_hist,
    output logic                  o_hist_vld,
    output logic [LZC_BYTE_W-1:0] o_scan,
    output logic                  o_scan_vld,
    output logic                  o_alive,
    output logic                  o_hit
);

    logic [LZC_BYTE_W-1:0] r_hist;
    logic                  r_hist_vld;
    logic [LZC_BYTE_W-1:0] r_scan;
    logic                  r_scan_vld;
    logic                  r_alive;

    // The cell still matches if it was matching, its scan byte is real
    // history and that byte equals the lookahead byte of this step.
    assign o_hit = r_alive && r_scan_vld && (r_scan == i_look);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= 1'b0;
            r_scan_vld <= 1'b0;
            r_alive    <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_hist_vld <= 1'b0;
            end else if (i_ctl.push) begin
                r_hist     <= i_hist_prev;
                r_hist_vld <= i_hist_vld_prev;
            end
            if (i_ctl.load) begin
                r_scan     <= r_hist;
                r_scan_vld <= r_hist_vld;
                r_alive    <= r_hist_vld;
            end else if (i_ctl.commit) begin
                r_scan     <= i_scan_prev;
                r_scan_vld <= i_scan_vld_prev;
                r_alive    <= o_hit;
            end
        end
    end

    assign o_hist     = r_hist;
    assign o_hist_vld = r_hist_vld;
    assign o_scan     = r_scan;
    assign o_scan_vld = r_scan_vld;
    assign o_alive    = r_alive;

endmodule

>>> rtl/lzc_find.sv
// Two-stage registered search for the farthest matching cell.
module lzc_find
    import lzc_pkg::*;
#(
    parameter int WINDOW_SIZE = LZC_WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic [WINDOW_SIZE-1:0] i_vec,
    output logic [LZC_DIST_W-1:0] o_dist
);

    localparam int NGRP = (WINDOW_SIZE + LZC_GROUP - 1) / LZC_GROUP;

    logic [NGRP*LZC_GROUP-1:0] w_pad;
    logic [NGRP-1:0]           r_grp_any;
    logic [LZC_GROUP_W-1:0]    r_grp_idx [NGRP];
    logic [NGRP-1:0]           n_grp_any;
    logic [LZC_GROUP_W-1:0]    n_grp_idx [NGRP];
    logic [LZC_DIST_W-1:0]     n_dist;

    assign w_pad = (NGRP*LZC_GROUP)'(i_vec);

    // First stage: the highest set bit inside each group.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp_any[g] = 1'b0;
            n_grp_idx[g] = '0;
            for (int b = 0; b < LZC_GROUP; b++) begin
                if (w_pad[g*LZC_GROUP + b]) begin
                    n_grp_any[g] = 1'b1;
                    n_grp_idx[g] = LZC_GROUP_W'(b);
                end
            end
        end
    end

    // Second stage: the highest group that holds a set bit.
    always_comb begin
        n_dist = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (r_grp_any[g]) begin
                n_dist = LZC_DIST_W'(g*LZC_GROUP) + LZC_DIST_W'(r_grp_idx[g])
                         + LZC_DIST_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_any <= n_grp_any;
        r_grp_idx <= n_grp_idx;
        o_dist    <= n_dist;
    end

endmodule

>>> rtl/lz77_greedy_byte_compressor_top.sv
// Top level of the greedy LZ77 byte compressor with its history cell chain.
//
// Input requests carry one byte and a last flag; a request is taken when
// i_in_valid is high and o_in_stall is low. Output requests carry one token:
// a literal or a (length, distance) match, with stream_end on the final one.
// Bytes queue in a lookahead of MAX_MATCH entries. A byte that neither fills
// the lookahead nor ends the stream is only stored and yields nothing.
// Otherwise a token is formed: the cell chain is armed, the scan advances one
// step per matched byte until a step finds no hit or the lookahead fill is
// reached, the farthest-distance search runs through S_FIND1 and S_FIND2, the
// token is registered once the output is free, and then each consumed byte is
// pushed into the history. The scan and the history push run through the
// chain of per-distance cells.
// On the last byte, tokens are formed until the lookahead is empty, and then
// the history is forgotten so that the next byte opens a new stream.
// The output register holds a token while the receiver stalls; the block
// waits before registering the next token but keeps its state meanwhile.
// After reset the history and lookahead are empty and no output is valid.
module lz77_greedy_byte_compressor_top
    import lzc_pkg::*;
#(
    parameter int WINDOW_SIZE = LZC_WINDOW_DEF,
    parameter int MAX_MATCH   = LZC_MAX_MATCH_DEF,
    parameter int MIN_MATCH   = LZC_MIN_MATCH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [LZC_BYTE_W-1:0]    i_data_byte,
    input  logic                     i_last_byte,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_is_match,
    output logic [LZC_BYTE_W-1:0]    o_literal_value,
    output logic [LZC_LEN_OUT_W-1:0] o_match_length,
    output logic [LZC_DIST_W-1:0]    o_match_distance,
    output logic                     o_stream_end
);

    // Fill, length and step counters hold 0..MAX_MATCH; the index reaches MAX_MATCH-1.
    localparam int LW = $clog2(MAX_MATCH + 1);
    localparam int IW = $clog2(MAX_MATCH);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_SCAN, S_FIND1, S_FIND2, S_EMIT, S_CONS
    } t_state;

    t_state                 r_state;
    logic [LZC_BYTE_W-1:0]  r_look [MAX_MATCH];
    logic [LW-1:0]          r_fill;
    logic                   r_flush;
    logic [LW-1:0]          r_k;
    logic [LW-1:0]          r_len;
    logic [LW-1:0]          r_used;
    logic                   r_out_valid;
    logic                   r_is_match;
    logic [LZC_BYTE_W-1:0]  r_literal;
    logic [LZC_LEN_OUT_W-1:0] r_mlen;
    logic [LZC_DIST_W-1:0]  r_mdist;
    logic                   r_end;

    t_cell_ctl              w_ctl;
    logic [LZC_BYTE_W-1:0]  w_hist     [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] w_hist_vld;
    logic [LZC_BYTE_W-1:0]  w_scan     [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] w_scan_vld;
    logic [WINDOW_SIZE-1:0] w_alive;
    logic [WINDOW_SIZE-1:0] w_hit;
    logic                   w_any;
    logic [LZC_BYTE_W-1:0]  w_look_k;
    logic [LZC_DIST_W-1:0]  w_dist;
    logic                   w_is_match;
    logic [LW-1:0]          w_used;
    logic                   w_last_cons;
    logic                   w_out_free;

    assign w_look_k    = r_look[r_k[IW-1:0]];
    assign w_any       = |w_hit;
    assign w_is_match  = (r_len >= LW'(MIN_MATCH));
    assign w_used      = w_is_match ? r_len : LW'(1);
    assign w_last_cons = (r_used == LW'(1));
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // The final consumed byte of a flushed stream clears the history instead.
    always_comb begin
        w_ctl.push   = (r_state == S_CONS) && !(w_last_cons && r_flush && (r_fill == LW'(1)));
        w_ctl.clear  = (r_state == S_CONS) && w_last_cons && r_flush && (r_fill == LW'(1));
        w_ctl.load   = (r_state == S_LOAD);
        w_ctl.commit = (r_state == S_SCAN) && w_any;
    end

    // Cell p holds the byte p+1 positions back. New history bytes enter at
    // cell 0, and during a scan each scan byte moves one cell farther away,
    // so cell p at step k compares the byte p+1-k back with lookahead byte k.
    for (genvar p = 0; p < WINDOW_SIZE; p++) begin : g_cell
        logic [LZC_BYTE_W-1:0] w_hp;
        logic                  w_hvp;
        logic [LZC_BYTE_W-1:0] w_sp;
        logic                  w_svp;
        if (p == 0) begin : g_head
            assign w_hp  = r_look[0];
            assign w_hvp = 1'b1;
            assign w_sp  = '0;
            assign w_svp = 1'b0;
        end else begin : g_body
            assign w_hp  = w_hist[p-1];
            assign w_hvp = w_hist_vld[p-1];
            assign w_sp  = w_scan[p-1];
            assign w_svp = w_scan_vld[p-1];
        end
        lzc_cell u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (w_ctl),
            .i_hist_prev     (w_hp),
            .i_hist_vld_prev (w_hvp),
            .i_scan_prev     (w_sp),
            .i_scan_vld_prev (w_svp),
            .i_look          (w_look_k),
            .o_hist          (w_hist[p]),
            .o_hist_vld      (w_hist_vld[p]),
            .o_scan          (w_scan[p]),
            .o_scan_vld      (w_scan_vld[p]),
            .o_alive         (w_alive[p]),
            .o_hit           (w_hit[p])
        );
    end

    // The cells still alive after the last successful step hold the longest
    // match; the farthest of them wins a tie.
    lzc_find #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_find (
        .i_clk  (i_clk),
        .i_vec  (w_alive),
        .o_dist (w_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_look[r_fill[IW-1:0]] <= i_data_byte;
                        r_fill  <= r_fill + LW'(1);
                        r_flush <= i_last_byte;
                        if (i_last_byte || (r_fill + LW'(1) == LW'(MAX_MATCH))) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_k     <= '0;
                    r_len   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_any) begin
                        r_len <= r_k + LW'(1);
                        if (r_k + LW'(1) < r_fill) begin
                            r_k <= r_k + LW'(1);
                        end else begin
                            r_state <= S_FIND1;
                        end
                    end else begin
                        r_state <= S_FIND1;
                    end
                end
                S_FIND1: begin
                    r_state <= S_FIND2;
                end
                S_FIND2: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_is_match  <= w_is_match;
                        r_literal   <= w_is_match ? '0 : r_look[0];
                        r_mlen      <= w_is_match ? LZC_LEN_OUT_W'(r_len) : '0;
                        r_mdist     <= w_is_match ? w_dist : '0;
                        r_end       <= r_flush && (r_fill == w_used);
                        r_used      <= w_used;
                        r_state     <= S_CONS;
                    end
                end
                S_CONS: begin
                    for (int i = 0; i < MAX_MATCH - 1; i++) begin
                        r_look[i] <= r_look[i+1];
                    end
                    r_fill <= r_fill - LW'(1);
                    r_used <= r_used - LW'(1);
                    if (w_last_cons) begin
                        if (r_fill == LW'(1)) begin
                            r_flush <= 1'b0;
                            r_state <= S_IDLE;
                        end else if (r_flush) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_is_match       = r_is_match;
    assign o_literal_value  = r_literal;
    assign o_match_length   = r_mlen;
    assign o_match_distance = r_mdist;
    assign o_stream_end     = r_end;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LW'(MAX_MATCH))
        else $error("lookahead fill exceeds its depth");

    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k < r_fill))
        else $error("scan step beyond waiting bytes");

    a_match_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_is_match) |-> (r_mdist != '0))
        else $error("match token with zero distance");

    a_emit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && r_out_valid && i_out_stall) |=> (r_state == S_EMIT))
        else $error("token registered over a stalled one");

    a_cons_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONS) |-> (r_fill != '0) && (r_used != '0) && (r_used <= r_fill))
        else $error("consuming more bytes than wait");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench of the greedy LZ77 byte compressor top level.
`timescale 1ns / 100ps

module testbench;
    import lzc_pkg::*;

    localparam int WIN      = 255;
    localparam int MAXM     = 15;
    localparam int MINM     = 3;
    localparam int N_RANDOM = 300;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       is_match;
        logic [7:0] lit;
        logic [3:0] len;
        logic [7:0] mdist;
        logic       send;
    } t_token;

    // One row of the directed table: a byte, its last flag, and whether the
    // expected tokens are typed in (only used for one-byte streams here).
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_token     tok;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_is_match;
    logic [7:0]  o_literal_value;
    logic [3:0]  o_match_length;
    logic [7:0]  o_match_distance;
    logic        o_stream_end;

    lz77_greedy_byte_compressor_top uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: history ring, its fill and head, and the lookahead.
    logic [7:0] hist_mem [256];
    int         hist_fill, hist_head;
    logic [7:0] ahead [MAXM];
    int         ahead_fill;

    t_token token_queue [$];
    int     error_count = 0;
    longint cycle_count = 0;
    bit     quiet_phase = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic void push_history(input logic [7:0] b);
        hist_mem[hist_head] = b;
        hist_head = (hist_head + 1) & 8'hFF;
        if (hist_fill < WIN) hist_fill++;
    endfunction

    // Forms one greedy token; the farthest distance wins a tie.
    function automatic t_token greedy_token();
        int     best_len, best_dist, run, used;
        t_token t;
        best_len = 0;
        best_dist = 0;
        for (int d = hist_fill; d >= 1; d--) begin
            run = 0;
            while (run < ahead_fill && run < d && run < MAXM &&
                   ahead[run] == hist_mem[(hist_head - d + run) & 8'hFF])
                run++;
            if (run > best_len) begin
                best_len = run;
                best_dist = d;
            end
        end
        t = '0;
        if (best_len >= MINM) begin
            t.is_match = 1'b1;
            t.len = best_len[3:0];
            t.mdist = best_dist[7:0];
            used = best_len;
        end else begin
            t.lit = ahead[0];
            used = 1;
        end
        for (int k = 0; k < used; k++) push_history(ahead[k]);
        for (int k = used; k < ahead_fill; k++) ahead[k - used] = ahead[k];
        ahead_fill -= used;
        return t;
    endfunction

    task automatic predict_tokens(input logic [7:0] b, input logic last);
        t_token t;
        int     n;
        n = 0;
        if (ahead_fill < MAXM) ahead[ahead_fill++] = b;
        if (last) begin
            while (ahead_fill > 0) begin
                t = greedy_token();
                if (ahead_fill == 0) t.send = 1'b1;
                token_queue.insert(token_queue.size(), t);
            end
            hist_fill = 0;
            hist_head = 0;
        end else if (ahead_fill >= MAXM) begin
            token_queue.insert(token_queue.size(), greedy_token());
        end
    endtask

    function automatic bit idle_now();
        return !quiet_phase && ($urandom_range(99) < 21);
    endfunction

    // Sends one request and waits until it is accepted.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (idle_now()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        predict_tokens(b, last);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Receiver side: random stall, compare each accepted token.
    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (token_queue.size() == 0) begin
                report_mismatch("unexpected token", 1, 0);
            end else begin
                want = token_queue.pop_front();
                if (o_is_match !== want.is_match)
                    report_mismatch("is_match", o_is_match, want.is_match);
                if (o_literal_value !== want.lit)
                    report_mismatch("literal_value", o_literal_value, want.lit);
                if (o_match_length !== want.len)
                    report_mismatch("match_length", o_match_length, want.len);
                if (o_match_distance !== want.mdist)
                    report_mismatch("match_distance", o_match_distance, want.mdist);
                if (o_stream_end !== want.send)
                    report_mismatch("stream_end", o_stream_end, want.send);
            end
        end
        i_out_stall <= idle_now();
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Directed table: a one-byte stream at each extreme, a run of one repeated
    // byte giving matches at growing distances, a tie between distances, and a
    // high literal; only one-byte streams carry typed-in tokens.
    t_row dir_rows [] = '{
        '{8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 4'd0, 8'd0, 1'b1}},
        '{8'hFF, 1'b1, 1'b1, '{1'b0, 8'hFF, 4'd0, 8'd0, 1'b1}},
        '{8'h41, 1'b0, 1'b0, '0}, '{8'h41, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0}, '{8'h41, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0}, '{8'h41, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0}, '{8'h41, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0}, '{8'h41, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0}, '{8'h41, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0}, '{8'h41, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0}, '{8'h41, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0}, '{8'hAA, 1'b0, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0},
        '{8'hAA, 1'b0, 1'b0, '0}, '{8'h55, 1'b1, 1'b0, '0},
        '{8'h7F, 1'b1, 1'b1, '{1'b0, 8'h7F, 4'd0, 8'd0, 1'b1}}
    };

    initial begin
        int     sent, len, alpha;
        logic [7:0] b;
        hist_fill = 0;
        hist_head = 0;
        ahead_fill = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_byte(dir_rows[r].data, dir_rows[r].last);
            // Typed-in rows override the predicted token with the table value.
            if (dir_rows[r].typed) begin
                token_queue.pop_back();
                token_queue.insert(token_queue.size(), dir_rows[r].tok);
            end
        end

        // Random streams: mostly small alphabets so that matches of many lengths
        // and distances appear, some plain noise.
        sent = 0;
        while (sent < N_RANDOM) begin
            quiet_phase = (sent > 100 && sent < 160);
            len = ($urandom_range(9) == 0) ? $urandom_range(300, 500)
                                           : $urandom_range(1, 60);
            if (len > N_RANDOM - sent) len = N_RANDOM - sent;
            alpha = ($urandom_range(3) == 0) ? 255 : $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
                b = (alpha == 255) ? 8'($urandom) : 8'($urandom_range(alpha))
                    ^ (($urandom_range(7) == 0) ? 8'hF0 : 8'h00);
                send_byte(b, k == len - 1);
                sent++;
            end
        end
        quiet_phase = 0;
        i_in_valid <= 1'b0;

        while (token_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && token_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
